// File: rtl/core/amf0_pkg.sv
// Package for the AMF0 script-data parser: parse phases, byte roles and field widths.
`timescale 1ns / 1ps

package amf0_pkg;

	// Field widths
	localparam int unsigned ByteW   = 8;
	localparam int unsigned SizeW   = 24;
	localparam int unsigned RoleW   = 4;
	localparam int unsigned ValueW  = 64;
	localparam int unsigned ItemW   = 16;
	localparam int unsigned EntryW  = 31;
	localparam int unsigned StrLenW = 16;
	localparam int unsigned FbcW    = 3;

	// Parse phase, one-hot
	typedef enum logic [11:0] {
		PH_IDLE    = 12'b0000_0000_0001,
		PH_TYPE    = 12'b0000_0000_0010,
		PH_STRLEN  = 12'b0000_0000_0100,
		PH_STRCHAR = 12'b0000_0000_1000,
		PH_COUNT   = 12'b0000_0001_0000,
		PH_KEYLEN  = 12'b0000_0010_0000,
		PH_KEYCHAR = 12'b0000_0100_0000,
		PH_VALTYPE = 12'b0000_1000_0000,
		PH_NUM     = 12'b0001_0000_0000,
		PH_BOOL    = 12'b0010_0000_0000,
		PH_VLEN    = 12'b0100_0000_0000,
		PH_VCHAR   = 12'b1000_0000_0000
	} phase_t;

	// Byte role codes reported per beat
	localparam logic [RoleW-1:0] ROLE_IGNORED = 4'd0;
	localparam logic [RoleW-1:0] ROLE_TYPE    = 4'd1;
	localparam logic [RoleW-1:0] ROLE_STRLEN  = 4'd2;
	localparam logic [RoleW-1:0] ROLE_STRCHAR = 4'd3;
	localparam logic [RoleW-1:0] ROLE_COUNT   = 4'd4;
	localparam logic [RoleW-1:0] ROLE_KEYLEN  = 4'd5;
	localparam logic [RoleW-1:0] ROLE_KEYCHAR = 4'd6;
	localparam logic [RoleW-1:0] ROLE_VALTYPE = 4'd7;
	localparam logic [RoleW-1:0] ROLE_NUM     = 4'd8;
	localparam logic [RoleW-1:0] ROLE_BOOL    = 4'd9;
	localparam logic [RoleW-1:0] ROLE_VLEN    = 4'd10;
	localparam logic [RoleW-1:0] ROLE_VCHAR   = 4'd11;

	// Item and value type codes
	localparam logic [ByteW-1:0] TYPE_STRING = 8'd2;
	localparam logic [ByteW-1:0] TYPE_ARRAY  = 8'd8;
	localparam logic [ByteW-1:0] VAL_NUMBER  = 8'd0;
	localparam logic [ByteW-1:0] VAL_BOOL    = 8'd1;
	localparam logic [ByteW-1:0] VAL_STRING  = 8'd2;

	// Field lengths in bytes and the type-byte threshold
	localparam logic [FbcW:0] LEN_BYTES   = 4'd2;
	localparam logic [FbcW:0] COUNT_BYTES = 4'd4;
	localparam logic [FbcW:0] NUM_BYTES   = 4'd8;
	localparam logic [SizeW-1:0] TYPE_MIN_LEFT = 24'd3;

endpackage

// File: rtl/core/amf0_script_data_parser.sv
// AMF0 script-data parser: one payload byte in, one role/field result out per beat.
// Each accepted byte waits in the input register; its result is loaded into the output
// register when the result register is free or drains, and is taken while out_ready is high.
// Throughput: one byte per cycle while the result side is not back-pressured; the parse
// state updates in the single stage between the input register and the result register.
// Reset: arst_n clears the handshake valids and all parse state (phase idle).
// A byte with tag_start restarts the parser with the new tag size.
`timescale 1ns / 1ps

module amf0_script_data_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [amf0_pkg::ByteW-1:0]        data_byte,
	input  logic                              tag_start,
	input  logic [amf0_pkg::SizeW-1:0]        tag_size,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [amf0_pkg::RoleW-1:0]        byte_role,
	output logic                              field_done,
	output logic [amf0_pkg::ValueW-1:0]       field_value,
	output logic [amf0_pkg::ItemW-1:0]        item_index,
	output logic [amf0_pkg::EntryW-1:0]       entry_index,
	output logic                              parse_stopped
);

	// Input register
	logic                         valid_s1;
	logic [amf0_pkg::ByteW-1:0]   data_byte_s1;
	logic                         tag_start_s1;
	logic [amf0_pkg::SizeW-1:0]   tag_size_s1;

	// Parse state
	amf0_pkg::phase_t               phase_q;
	logic [amf0_pkg::SizeW-1:0]     bytes_left_q;
	logic [amf0_pkg::FbcW-1:0]      fbc_q;
	logic [amf0_pkg::StrLenW-1:0]   str_left_q;
	logic [amf0_pkg::EntryW-1:0]    entries_left_q;
	logic [amf0_pkg::ValueW-1:0]    assemble_q;
	logic [amf0_pkg::ItemW-1:0]     item_cnt_q;
	logic [amf0_pkg::EntryW-1:0]    entry_cnt_q;

	// Next-state and result values
	amf0_pkg::phase_t               ph;
	logic [amf0_pkg::SizeW-1:0]     bl;
	logic [amf0_pkg::FbcW-1:0]      fbc;
	logic [amf0_pkg::StrLenW-1:0]   sbl;
	logic [amf0_pkg::EntryW-1:0]    el;
	logic [amf0_pkg::ValueW-1:0]    asm_v;
	logic [amf0_pkg::ItemW-1:0]     ic;
	logic [amf0_pkg::EntryW-1:0]    ec;
	logic [amf0_pkg::EntryW-1:0]    eidx;
	logic [amf0_pkg::RoleW-1:0]     role;
	logic                           done;
	logic                           stopped;
	logic [amf0_pkg::ValueW-1:0]    val;
	logic                           fin;
	logic                           field_full;
	logic [amf0_pkg::FbcW:0]        need;
	logic [amf0_pkg::FbcW:0]        fbc_inc;
	logic [amf0_pkg::ByteW-1:0]     b;

	logic advance;

	// Handshake: the stage moves when the result register is free or drains
	assign advance   = valid_s1 && (!out_valid || out_ready);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_byte_s1 <= data_byte;
			tag_start_s1 <= tag_start;
			tag_size_s1  <= tag_size;
		end
	end

	// Per-byte parse step
	always_comb begin
		b       = data_byte_s1;
		ph      = phase_q;
		bl      = bytes_left_q;
		fbc     = fbc_q;
		sbl     = str_left_q;
		el      = entries_left_q;
		asm_v   = assemble_q;
		ic      = item_cnt_q;
		ec      = entry_cnt_q;
		role    = amf0_pkg::ROLE_IGNORED;
		done    = 1'b0;
		stopped = 1'b0;
		val     = '0;
		fin     = 1'b0;
		need    = amf0_pkg::LEN_BYTES;

		// Tag start restarts everything
		if (tag_start_s1) begin
			ph    = amf0_pkg::PH_TYPE;
			bl    = tag_size_s1;
			fbc   = '0;
			sbl   = '0;
			el    = '0;
			asm_v = '0;
			ic    = '0;
			ec    = '0;
		end
		eidx = ec;

		// Out of payload, or too short for another item
		if (ph != amf0_pkg::PH_IDLE && bl == '0)
			ph = amf0_pkg::PH_IDLE;
		if (ph == amf0_pkg::PH_TYPE && bl <= amf0_pkg::TYPE_MIN_LEFT)
			ph = amf0_pkg::PH_IDLE;

		// Field assembly shared by the multi-byte phases
		case (ph)
			amf0_pkg::PH_COUNT: need = amf0_pkg::COUNT_BYTES;
			amf0_pkg::PH_NUM:   need = amf0_pkg::NUM_BYTES;
			default:            need = amf0_pkg::LEN_BYTES;
		endcase
		fbc_inc    = {1'b0, fbc} + 1'b1;
		field_full = (fbc_inc >= need);

		if (ph != amf0_pkg::PH_IDLE) begin
			bl = bl - 1'b1;
			case (ph)
				amf0_pkg::PH_TYPE: begin
					role = amf0_pkg::ROLE_TYPE;
					done = 1'b1;
					val  = {56'd0, b};
					if (ic != '1)
						ic = ic + 1'b1;
					if (b == amf0_pkg::TYPE_STRING) begin
						ph = amf0_pkg::PH_STRLEN;  fbc = '0; asm_v = '0;
					end else if (b == amf0_pkg::TYPE_ARRAY) begin
						ph = amf0_pkg::PH_COUNT;   fbc = '0; asm_v = '0;
					end
				end
				amf0_pkg::PH_STRLEN, amf0_pkg::PH_KEYLEN, amf0_pkg::PH_VLEN: begin
					case (ph)
						amf0_pkg::PH_STRLEN: role = amf0_pkg::ROLE_STRLEN;
						amf0_pkg::PH_KEYLEN: role = amf0_pkg::ROLE_KEYLEN;
						default:             role = amf0_pkg::ROLE_VLEN;
					endcase
					asm_v = {asm_v[amf0_pkg::ValueW-9:0], b};
					if (field_full) begin
						fbc  = '0;
						done = 1'b1;
						val  = {48'd0, asm_v[amf0_pkg::StrLenW-1:0]};
						sbl  = asm_v[amf0_pkg::StrLenW-1:0];
						if (sbl != '0) begin
							case (ph)
								amf0_pkg::PH_STRLEN: ph = amf0_pkg::PH_STRCHAR;
								amf0_pkg::PH_KEYLEN: ph = amf0_pkg::PH_KEYCHAR;
								default:             ph = amf0_pkg::PH_VCHAR;
							endcase
						end else begin
							case (ph)
								amf0_pkg::PH_STRLEN: ph = amf0_pkg::PH_TYPE;
								amf0_pkg::PH_KEYLEN: ph = amf0_pkg::PH_VALTYPE;
								default:             fin = 1'b1;
							endcase
						end
					end else begin
						fbc = fbc_inc[amf0_pkg::FbcW-1:0];
					end
				end
				amf0_pkg::PH_STRCHAR, amf0_pkg::PH_KEYCHAR, amf0_pkg::PH_VCHAR: begin
					case (ph)
						amf0_pkg::PH_STRCHAR: role = amf0_pkg::ROLE_STRCHAR;
						amf0_pkg::PH_KEYCHAR: role = amf0_pkg::ROLE_KEYCHAR;
						default:              role = amf0_pkg::ROLE_VCHAR;
					endcase
					done = 1'b1;
					val  = {56'd0, b};
					sbl  = sbl - 1'b1;
					if (sbl == '0) begin
						case (ph)
							amf0_pkg::PH_STRCHAR: ph = amf0_pkg::PH_TYPE;
							amf0_pkg::PH_KEYCHAR: ph = amf0_pkg::PH_VALTYPE;
							default:              fin = 1'b1;
						endcase
					end
				end
				amf0_pkg::PH_COUNT: begin
					role  = amf0_pkg::ROLE_COUNT;
					asm_v = {asm_v[amf0_pkg::ValueW-9:0], b};
					if (field_full) begin
						fbc  = '0;
						done = 1'b1;
						val  = {32'd0, asm_v[31:0]};
						// A count with the top bit set means no entries
						el   = asm_v[31] ? '0 : asm_v[amf0_pkg::EntryW-1:0];
						ec   = '0;
						if (el == '0) begin
							ph = amf0_pkg::PH_TYPE;
						end else begin
							ph = amf0_pkg::PH_KEYLEN; fbc = '0; asm_v = '0;
						end
					end else begin
						fbc = fbc_inc[amf0_pkg::FbcW-1:0];
					end
				end
				amf0_pkg::PH_VALTYPE: begin
					role = amf0_pkg::ROLE_VALTYPE;
					done = 1'b1;
					val  = {56'd0, b};
					if (b == amf0_pkg::VAL_NUMBER) begin
						ph = amf0_pkg::PH_NUM;  fbc = '0; asm_v = '0;
					end else if (b == amf0_pkg::VAL_BOOL) begin
						ph = amf0_pkg::PH_BOOL;
					end else if (b == amf0_pkg::VAL_STRING) begin
						ph = amf0_pkg::PH_VLEN; fbc = '0; asm_v = '0;
					end else begin
						stopped = 1'b1;
						ph      = amf0_pkg::PH_IDLE;
					end
				end
				amf0_pkg::PH_NUM: begin
					role  = amf0_pkg::ROLE_NUM;
					asm_v = {asm_v[amf0_pkg::ValueW-9:0], b};
					if (field_full) begin
						fbc  = '0;
						done = 1'b1;
						val  = asm_v;
						fin  = 1'b1;
					end else begin
						fbc = fbc_inc[amf0_pkg::FbcW-1:0];
					end
				end
				amf0_pkg::PH_BOOL: begin
					role = amf0_pkg::ROLE_BOOL;
					done = 1'b1;
					val  = {56'd0, b};
					fin  = 1'b1;
				end
				default: begin
					ph   = amf0_pkg::PH_IDLE;
					role = amf0_pkg::ROLE_IGNORED;
				end
			endcase

			// End of one array entry
			if (fin) begin
				ec = ec + 1'b1;
				el = el - 1'b1;
				if (el == '0) begin
					ph = amf0_pkg::PH_TYPE;
				end else begin
					ph = amf0_pkg::PH_KEYLEN; fbc = '0; asm_v = '0;
				end
			end
		end
	end

	// Parse state commits as the byte moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= amf0_pkg::PH_IDLE;
			bytes_left_q   <= '0;
			fbc_q          <= '0;
			str_left_q     <= '0;
			entries_left_q <= '0;
			assemble_q     <= '0;
			item_cnt_q     <= '0;
			entry_cnt_q    <= '0;
		end else if (advance) begin
			phase_q        <= ph;
			bytes_left_q   <= bl;
			fbc_q          <= fbc;
			str_left_q     <= sbl;
			entries_left_q <= el;
			assemble_q     <= asm_v;
			item_cnt_q     <= ic;
			entry_cnt_q    <= ec;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_role     <= role;
			field_done    <= done;
			field_value   <= val;
			item_index    <= ic;
			entry_index   <= eidx;
			parse_stopped <= stopped;
		end
	end

endmodule

// File: tb/amf0_parse_checker.sv
// Checker for amf0_script_data_parser: predicts each result beat from the accepted bytes and compares.
`timescale 1ns / 1ps

module amf0_parse_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [amf0_pkg::ByteW-1:0]  data_byte,
	input  logic                        tag_start,
	input  logic [amf0_pkg::SizeW-1:0]  tag_size,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [amf0_pkg::RoleW-1:0]  byte_role,
	input  logic                        field_done,
	input  logic [amf0_pkg::ValueW-1:0] field_value,
	input  logic [amf0_pkg::ItemW-1:0]  item_index,
	input  logic [amf0_pkg::EntryW-1:0] entry_index,
	input  logic                        parse_stopped,
	output int                          fail_count,
	output int                          pending,
	output int                          results_checked,
	output int                          stops_seen
);

	import amf0_pkg::*;

	typedef struct packed {
		logic [RoleW-1:0]  role;
		logic              done;
		logic [ValueW-1:0] value;
		logic [ItemW-1:0]  item;
		logic [EntryW-1:0] entry;
		logic              stopped;
	} byte_result_t;

	// Parser state mirrored by the predictor
	phase_t              phase_q;
	logic [SizeW-1:0]    bytes_left;
	logic [FbcW-1:0]     field_cnt;
	logic [StrLenW-1:0]  str_left;
	logic [EntryW-1:0]   entries_left;
	logic [ValueW-1:0]   assemble;
	logic [ItemW-1:0]    item_cnt;
	logic [EntryW-1:0]   entry_cnt;

	byte_result_t byte_results_q[$];
	byte_result_t want;

	task automatic report_failure(input string msg);
		$display("MISMATCH at result %0d (%0t): %s", results_checked, $realtime, msg);
		fail_count++;
	endtask

	function automatic void start_field(input phase_t p);
		phase_q = p;
		field_cnt = '0;
		assemble = '0;
	endfunction

	// Shift a byte into the big-endian field; true once need bytes are in
	function automatic bit shift_field(input logic [ByteW-1:0] b, input logic [FbcW:0] need);
		assemble = {assemble[ValueW-ByteW-1:0], b};
		if ({1'b0, field_cnt} + 4'd1 >= need) begin
			field_cnt = '0;
			return 1'b1;
		end
		field_cnt = field_cnt + 1'b1;
		return 1'b0;
	endfunction

	function automatic void entry_done();
		entry_cnt = entry_cnt + 1'b1;
		entries_left = entries_left - 1'b1;
		if (entries_left == '0)
			phase_q = PH_TYPE;
		else
			start_field(PH_KEYLEN);
	endfunction

	// Expected result for one accepted byte; advances the mirrored state
	task automatic predict_byte_result(input logic [ByteW-1:0] b, input logic st,
			input logic [SizeW-1:0] sz, output byte_result_t r);
		logic [31:0] count;
		r = '0;
		if (st) begin
			phase_q = PH_TYPE;
			bytes_left = sz;
			field_cnt = '0;
			str_left = '0;
			entries_left = '0;
			assemble = '0;
			item_cnt = '0;
			entry_cnt = '0;
		end
		r.entry = entry_cnt;

		// Out of tag bytes, or too few left for another item
		if (phase_q != PH_IDLE && bytes_left == '0)
			phase_q = PH_IDLE;
		if (phase_q == PH_TYPE && bytes_left <= TYPE_MIN_LEFT)
			phase_q = PH_IDLE;

		if (phase_q != PH_IDLE) begin
			bytes_left = bytes_left - 1'b1;
			case (phase_q)
				PH_TYPE:    r.role = ROLE_TYPE;
				PH_STRLEN:  r.role = ROLE_STRLEN;
				PH_STRCHAR: r.role = ROLE_STRCHAR;
				PH_COUNT:   r.role = ROLE_COUNT;
				PH_KEYLEN:  r.role = ROLE_KEYLEN;
				PH_KEYCHAR: r.role = ROLE_KEYCHAR;
				PH_VALTYPE: r.role = ROLE_VALTYPE;
				PH_NUM:     r.role = ROLE_NUM;
				PH_BOOL:    r.role = ROLE_BOOL;
				PH_VLEN:    r.role = ROLE_VLEN;
				PH_VCHAR:   r.role = ROLE_VCHAR;
				default:    r.role = ROLE_IGNORED;
			endcase

			case (phase_q)
				PH_TYPE: begin
					r.done = 1'b1;
					r.value = 64'(b);
					if (item_cnt != '1)
						item_cnt = item_cnt + 1'b1;
					if (b == TYPE_STRING)
						start_field(PH_STRLEN);
					else if (b == TYPE_ARRAY)
						start_field(PH_COUNT);
				end
				PH_STRLEN, PH_KEYLEN, PH_VLEN: begin
					if (shift_field(b, LEN_BYTES)) begin
						r.done = 1'b1;
						r.value = 64'(assemble[StrLenW-1:0]);
						str_left = assemble[StrLenW-1:0];
						if (str_left != '0) begin
							if (phase_q == PH_STRLEN)
								phase_q = PH_STRCHAR;
							else if (phase_q == PH_KEYLEN)
								phase_q = PH_KEYCHAR;
							else
								phase_q = PH_VCHAR;
						end else if (phase_q == PH_STRLEN)
							phase_q = PH_TYPE;
						else if (phase_q == PH_KEYLEN)
							phase_q = PH_VALTYPE;
						else
							entry_done();
					end
				end
				PH_STRCHAR, PH_KEYCHAR, PH_VCHAR: begin
					r.done = 1'b1;
					r.value = 64'(b);
					str_left = str_left - 1'b1;
					if (str_left == '0) begin
						if (phase_q == PH_STRCHAR)
							phase_q = PH_TYPE;
						else if (phase_q == PH_KEYCHAR)
							phase_q = PH_VALTYPE;
						else
							entry_done();
					end
				end
				PH_COUNT: begin
					if (shift_field(b, COUNT_BYTES)) begin
						count = assemble[31:0];
						r.done = 1'b1;
						r.value = 64'(count);
						// bit 31 set means an empty array
						entries_left = count[31] ? '0 : count[30:0];
						entry_cnt = '0;
						if (entries_left == '0)
							phase_q = PH_TYPE;
						else
							start_field(PH_KEYLEN);
					end
				end
				PH_VALTYPE: begin
					r.done = 1'b1;
					r.value = 64'(b);
					if (b == VAL_NUMBER)
						start_field(PH_NUM);
					else if (b == VAL_BOOL)
						phase_q = PH_BOOL;
					else if (b == VAL_STRING)
						start_field(PH_VLEN);
					else begin
						r.stopped = 1'b1;
						phase_q = PH_IDLE;
					end
				end
				PH_NUM: begin
					if (shift_field(b, NUM_BYTES)) begin
						r.done = 1'b1;
						r.value = assemble;
						entry_done();
					end
				end
				PH_BOOL: begin
					r.done = 1'b1;
					r.value = 64'(b);
					entry_done();
				end
				default: begin
					phase_q = PH_IDLE;
					r.role = ROLE_IGNORED;
				end
			endcase
		end
		r.item = item_cnt;
	endtask

	// Predict on each input beat, compare on each output beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q = PH_IDLE;
			bytes_left = '0;
			field_cnt = '0;
			str_left = '0;
			entries_left = '0;
			assemble = '0;
			item_cnt = '0;
			entry_cnt = '0;
			byte_results_q.delete();
			fail_count = 0;
			pending = 0;
			results_checked = 0;
			stops_seen = 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_byte_result(data_byte, tag_start, tag_size, want);
				byte_results_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (byte_results_q.size() == 0)
					report_failure("result beat with no byte outstanding");
				else begin
					want = byte_results_q.pop_front();
					if (byte_role !== want.role)
						report_failure($sformatf("byte_role %0d, expected %0d",
							byte_role, want.role));
					if (field_done !== want.done)
						report_failure($sformatf("field_done %0b, expected %0b",
							field_done, want.done));
					if (field_value !== want.value)
						report_failure($sformatf("field_value %h, expected %h",
							field_value, want.value));
					if (item_index !== want.item)
						report_failure($sformatf("item_index %0d, expected %0d",
							item_index, want.item));
					if (entry_index !== want.entry)
						report_failure($sformatf("entry_index %0d, expected %0d",
							entry_index, want.entry));
					if (parse_stopped !== want.stopped)
						report_failure($sformatf("parse_stopped %0b, expected %0b",
							parse_stopped, want.stopped));
					if (want.stopped)
						stops_seen++;
				end
				results_checked++;
			end
			pending = byte_results_q.size();
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top for amf0_script_data_parser: byte stimulus, handshake idling and verdict.
`timescale 1ns / 1ps

module tb;

	import amf0_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int TOTAL_BEATS  = 850;
	localparam int DRAIN_CYCLES = 10;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [ByteW-1:0]    data_byte;
	logic                tag_start;
	logic [SizeW-1:0]    tag_size;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [RoleW-1:0]    byte_role;
	logic                field_done;
	logic [ValueW-1:0]   field_value;
	logic [ItemW-1:0]    item_index;
	logic [EntryW-1:0]   entry_index;
	logic                parse_stopped;

	int fail_count;
	int pending;
	int results_checked;
	int stops_seen;

	int beats_sent = 0;
	int tags_sent = 0;
	int in_stall_cycles = 0;
	int cycle_count;
	bit sender_idles = 1'b0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;

	logic [ByteW-1:0] payload[$];

	amf0_script_data_parser dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.tag_start    (tag_start),
		.tag_size     (tag_size),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.byte_role    (byte_role),
		.field_done   (field_done),
		.field_value  (field_value),
		.item_index   (item_index),
		.entry_index  (entry_index),
		.parse_stopped(parse_stopped)
	);

	amf0_parse_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.data_byte      (data_byte),
		.tag_start      (tag_start),
		.tag_size       (tag_size),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.byte_role      (byte_role),
		.field_done     (field_done),
		.field_value    (field_value),
		.item_index     (item_index),
		.entry_index    (entry_index),
		.parse_stopped  (parse_stopped),
		.fail_count     (fail_count),
		.pending        (pending),
		.results_checked(results_checked),
		.stops_seen     (stops_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Cycles in which the parser refused an offered byte
	always @(posedge clk) begin
		if (in_valid && !in_ready)
			in_stall_cycles++;
	end

	function automatic void push_len16(input int n);
		payload.push_back(8'(n >> 8));
		payload.push_back(8'(n));
	endfunction

	function automatic void push_chars(input int n);
		repeat (n) payload.push_back(8'($urandom_range(0, 255)));
	endfunction

	// Offer one byte beat; called and returns at a falling edge
	task automatic send_beat(input logic [ByteW-1:0] b, input logic st, input logic [SizeW-1:0] sz);
		int gap;
		gap = sender_idles ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		tag_start <= st;
		tag_size <= sz;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Send the first n bytes of the built payload as a tag of size sz
	task automatic send_tag(input logic [SizeW-1:0] sz, input int n);
		for (int i = 0; i < n; i++)
			send_beat(payload[i], i == 0, (i == 0) ? sz : 24'($urandom));
		beats_sent += n;
		tags_sent++;
		payload.delete();
	endtask

	// Result side: random stalls in stretches, plus one long hold-off
	initial begin : receiver
		int stall;
		int run_left;
		bit idles;
		run_left = 0;
		idles = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (run_left == 0) begin
				idles = $urandom_range(0, 2) != 0;
				run_left = $urandom_range(20, 60);
			end
			run_left--;
			stall = idles ? $urandom_range(0, 19) : 0;
			if (hold_req) begin
				hold_req = 1'b0;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			@(negedge clk);
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
		$display("amf0_script_data_parser verification failed");
		$finish;
	end

	initial begin : stimulus
		int n;
		int len;
		int pick;
		int shape;
		int k;
		logic [31:0] count;
		logic [ByteW-1:0] b;
		logic [SizeW-1:0] sz;

		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = '0;
		tag_start = 1'b0;
		tag_size = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// Directed: a stray byte before any tag is ignored
		sender_idles = 1'b1;
		send_beat(8'hFF, 1'b0, 24'hFFFFFF);
		beats_sent++;

		// Empty string, count with bit 31 set, then too few bytes for a type
		payload = '{TYPE_STRING, 8'h00, 8'h00, TYPE_ARRAY, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00};
		send_tag(24'd9, 9);

		// Two entries: empty key with a boolean, one-char key with an empty string
		payload = '{TYPE_ARRAY, 8'h00, 8'h00, 8'h00, 8'h02, 8'h00, 8'h00, VAL_BOOL, 8'hFF,
			8'h00, 8'h01, 8'h00, VAL_STRING, 8'h00, 8'h00};
		send_tag(24'd15, 15);

		// Unknown value type stops the tag; the next byte is ignored
		payload = '{TYPE_ARRAY, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h07, 8'h55};
		send_tag(24'hFFFFFF, 9);

		// New tag while stopped; other item type; size runs out mid-string
		payload = '{8'h05, TYPE_STRING, 8'h00, 8'h05, 8'h41, 8'h42, 8'h43};
		send_tag(24'd6, 7);

		// String cut short by the next tag_start
		payload = '{TYPE_STRING, 8'h00, 8'h09, 8'h61};
		send_tag(24'd40, 4);

		// Random tags, mostly well formed with random content
		while (beats_sent < TOTAL_BEATS) begin
			sender_idles = $urandom_range(0, 3) != 0;
			if (!hold_done && beats_sent >= 200) begin
				hold_req = 1'b1;
				hold_done = 1'b1;
				sender_idles = 1'b0;
			end
			if ($urandom_range(0, 4) != 0) begin
				n = $urandom_range(1, 4);
				repeat (n) begin
					pick = $urandom_range(0, 9);
					if (pick <= 3) begin
						payload.push_back(TYPE_STRING);
						len = $urandom_range(0, 6);
						push_len16(len);
						push_chars(len);
					end else if (pick <= 7) begin
						payload.push_back(TYPE_ARRAY);
						k = $urandom_range(0, 3);
						shape = $urandom_range(0, 9);
						if (shape == 0)
							count = {1'b1, 31'($urandom)};
						else if (shape == 1)
							count = {1'b0, 31'($urandom)};
						else
							count = 32'(k);
						for (int j = 3; j >= 0; j--)
							payload.push_back(count[8*j +: 8]);
						repeat (k) begin
							len = $urandom_range(0, 4);
							push_len16(len);
							push_chars(len);
							pick = $urandom_range(0, 11);
							if (pick <= 3) begin
								payload.push_back(VAL_NUMBER);
								shape = $urandom_range(0, 3);
								repeat (8) payload.push_back(shape == 0 ? 8'h00 :
									shape == 1 ? 8'hFF : 8'($urandom_range(0, 255)));
							end else if (pick <= 6) begin
								payload.push_back(VAL_BOOL);
								push_chars(1);
							end else if (pick <= 10) begin
								payload.push_back(VAL_STRING);
								len = $urandom_range(0, 4);
								push_len16(len);
								push_chars(len);
							end else
								// unsupported value type
								payload.push_back(8'($urandom_range(3, 255)));
						end
					end else begin
						b = 8'($urandom_range(0, 255));
						if (b == TYPE_STRING || b == TYPE_ARRAY)
							b = b ^ 8'h01;
						payload.push_back(b);
					end
				end

				// Tag size: exact, padded, short, cut by the next tag, or extreme
				len = payload.size();
				pick = $urandom_range(0, 9);
				if (pick == 6) begin
					k = $urandom_range(1, 5);
					push_chars(k);
					send_tag(24'(len + k), len + k);
				end else if (pick == 7)
					send_tag(24'($urandom_range(0, len - 1)), len);
				else if (pick == 8)
					send_tag(24'(len), $urandom_range(1, len));
				else if (pick == 9) begin
					shape = $urandom_range(0, 2);
					sz = (shape == 0) ? 24'h000000 : (shape == 1) ? 24'hFFFFFF : 24'($urandom);
					send_tag(sz, len);
				end else
					send_tag(24'(len), len);
			end else begin
				// Noise: random bytes, as a tag or as loose beats
				n = $urandom_range(1, 10);
				push_chars(n);
				pick = $urandom_range(0, 3);
				if (pick == 0) begin
					foreach (payload[i])
						send_beat(payload[i], 1'b0, 24'($urandom));
					beats_sent += n;
					payload.delete();
				end else
					send_tag(pick == 1 ? 24'($urandom_range(0, 15)) : 24'($urandom), n);
			end
		end
		in_valid <= 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Sent %0d byte beats in %0d tags; %0d results checked, %0d stopped tags",
			beats_sent, tags_sent, results_checked, stops_seen);
		$display("Input stalled for %0d cycles under output back-pressure", in_stall_cycles);
		if (fail_count == 0 && pending == 0)
			$display("amf0_script_data_parser verification clean");
		else
			$display("amf0_script_data_parser verification failed");
		$finish;
	end

endmodule
